FILE: src/sign_pack_tile_transpose_macros.svh
// Assertion macros shared by the sign pack / transpose block.
`ifndef SIGN_PACK_TILE_TRANSPOSE_MACROS_SVH
`define SIGN_PACK_TILE_TRANSPOSE_MACROS_SVH

// antecedent and consequent in the same cycle
`define SPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the next cycle
`define SPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// consequent in a later cycle than the antecedent
`define SPT_ASSERT_LATER2(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

FILE: src/spt_pkg.sv
// Package: shared constants and types of the sign pack / transpose block.
`default_nettype none
package spt_pkg;

	localparam int TILE_SIZE_DEF   = 32;
	localparam int SAMPLE_BITS_DEF = 32;

	localparam int DIM_W     = 16;
	localparam int OUT_COL_W = 11;

	localparam logic [DIM_W-1:0] DIM_RESET = 16'd32;

	// register indexes (paddr[2])
	localparam logic [0:0] REG_NUM_ROWS = 1'b0;
	localparam logic [0:0] REG_NUM_COLS = 1'b1;

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_FLUSH = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_all;
	} store_ctl_t;

endpackage
`default_nettype wire

FILE: src/spt_store.sv
// Sign store: one memory entry per tile column, valid bits, write-to-read forwarding.
`default_nettype none
module spt_store import spt_pkg::*; #(
	parameter int TILE_SIZE = TILE_SIZE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire store_ctl_t                   ctl,
	input  wire logic [$clog2(TILE_SIZE)-1:0] rd_addr,
	input  wire logic [$clog2(TILE_SIZE)-1:0] wr_addr,
	input  wire logic [TILE_SIZE-1:0]         wr_data,
	output logic      [TILE_SIZE-1:0]         rd_word
);

	logic [TILE_SIZE-1:0] mem [TILE_SIZE];
	logic [TILE_SIZE-1:0] mem_q;
	logic [TILE_SIZE-1:0] fwd_q;
	logic [TILE_SIZE-1:0] vld_q;
	logic                 fwd_hit_q;
	logic                 vld_rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			mem_q <= mem[rd_addr];
			fwd_q <= wr_data;
		end
	end

	// read-first memory: a write at the read edge is taken from fwd_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			fwd_hit_q <= 1'b0;
			vld_rd_q  <= 1'b0;
		end else begin
			if (ctl.rd_en) begin
				fwd_hit_q <= ctl.wr_en && (wr_addr == rd_addr);
				vld_rd_q  <= vld_q[rd_addr];
			end
			if (ctl.clr_all) begin
				vld_q <= '0;
			end else if (ctl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_word = fwd_hit_q ? fwd_q : (vld_rd_q ? mem_q : '0);

endmodule
`default_nettype wire

FILE: src/spt_ctrl.sv
// Control: tile positions, block counters, read-modify-write path and column drain.
`default_nettype none
module spt_ctrl import spt_pkg::*; #(
	parameter int TILE_SIZE = TILE_SIZE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         restart,
	input  wire logic [DIM_W-1:0]             nr_eff,
	input  wire logic [DIM_W-1:0]             nc_eff,
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire logic                         item_neg,
	input  wire logic                         out_free,
	input  wire logic [TILE_SIZE-1:0]         rd_word,
	output store_ctl_t                        st_ctl,
	output logic      [$clog2(TILE_SIZE)-1:0] rd_addr,
	output logic      [$clog2(TILE_SIZE)-1:0] wr_addr,
	output logic      [TILE_SIZE-1:0]         wr_data,
	output logic                              out_load,
	output logic      [TILE_SIZE-1:0]         out_word_d,
	output logic      [DIM_W-1:0]             out_row_d,
	output logic      [OUT_COL_W-1:0]         out_col_d,
	output logic                              out_last_d
);

	localparam int POS_W  = $clog2(TILE_SIZE);
	localparam int CNT_W  = POS_W + 1;
	localparam int BLK_W  = $clog2((65535 + TILE_SIZE - 1) / TILE_SIZE);
	localparam int PROD_W = BLK_W + POS_W + 1;

	// valid lines of block blk in a dimension of size total
	function automatic logic [CNT_W-1:0] span(input logic [DIM_W-1:0] total,
	                                          input logic [BLK_W-1:0] blk);
		logic [PROD_W-1:0] start;
		logic [PROD_W-1:0] rem;
		start = PROD_W'(blk) * PROD_W'(TILE_SIZE);
		rem   = PROD_W'(total) - start;
		if (start >= PROD_W'(total)) begin
			span = CNT_W'(1);
		end else if (rem < PROD_W'(TILE_SIZE)) begin
			span = rem[CNT_W-1:0];
		end else begin
			span = CNT_W'(TILE_SIZE);
		end
	endfunction

	state_t            state_q, state_d;
	logic [POS_W-1:0]  col_q, row_q;
	logic [BLK_W-1:0]  rb_q, cb_q;
	logic [CNT_W-1:0]  drain_idx_q;
	logic              pend_q;
	logic [POS_W-1:0]  pend_idx_q;

	logic              vld_s1, neg_s1;
	logic [POS_W-1:0]  col_s1, row_s1;

	logic [CNT_W-1:0]  rows_here, cols_here;
	logic              accept, col_end, row_end, tile_end;
	logic              drain_rd, drain_done;
	logic [BLK_W:0]    rb_inc, cb_inc;
	logic              rb_wrap, cb_wrap;
	logic [PROD_W-1:0] out_row_full;

	assign rows_here = span(nr_eff, rb_q);
	assign cols_here = span(nc_eff, cb_q);

	assign item_stall = (state_q != ST_RUN);
	assign accept     = item_valid && !item_stall;
	assign col_end    = !(CNT_W'(col_q) + CNT_W'(1) < cols_here);
	assign row_end    = !(CNT_W'(row_q) + CNT_W'(1) < rows_here);
	assign tile_end   = accept && col_end && row_end;

	assign drain_rd   = (state_q == ST_DRAIN) && (drain_idx_q < cols_here)
	                    && (!pend_q || out_free);
	assign drain_done = (state_q == ST_DRAIN) && (drain_idx_q == cols_here) && !pend_q;
	assign out_load   = (state_q == ST_DRAIN) && pend_q && out_free;

	assign rb_inc  = {1'b0, rb_q} + (BLK_W+1)'(1);
	assign cb_inc  = {1'b0, cb_q} + (BLK_W+1)'(1);
	assign rb_wrap = PROD_W'(rb_inc) * PROD_W'(TILE_SIZE) >= PROD_W'(nr_eff);
	assign cb_wrap = PROD_W'(cb_inc) * PROD_W'(TILE_SIZE) >= PROD_W'(nc_eff);

	// store port
	assign st_ctl.rd_en   = accept || drain_rd;
	assign st_ctl.wr_en   = vld_s1;
	assign st_ctl.clr_all = restart || drain_done;
	assign rd_addr = (state_q == ST_DRAIN) ? drain_idx_q[POS_W-1:0] : col_q;
	assign wr_addr = col_s1;
	assign wr_data = rd_word
	                 | (neg_s1 ? '0 : (TILE_SIZE'(1) << (POS_W'(TILE_SIZE - 1) - row_s1)));

	// drain word
	assign out_row_full = PROD_W'(cb_q) * PROD_W'(TILE_SIZE) + PROD_W'(pend_idx_q);
	assign out_word_d   = rd_word;
	assign out_row_d    = out_row_full[DIM_W-1:0];
	assign out_col_d    = OUT_COL_W'(rb_q);
	assign out_last_d   = (CNT_W'(pend_idx_q) + CNT_W'(1) == cols_here);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN:   if (tile_end) state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_DRAIN;
			ST_DRAIN: if (drain_done) state_d = ST_RUN;
			default:  state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk) begin
		col_s1 <= col_q;
		row_s1 <= row_q;
		neg_s1 <= item_neg;
		if (drain_rd) begin
			pend_idx_q <= drain_idx_q[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			col_q       <= '0;
			row_q       <= '0;
			rb_q        <= '0;
			cb_q        <= '0;
			drain_idx_q <= '0;
			pend_q      <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			vld_s1 <= accept;
			if (restart) begin
				state_q     <= ST_RUN;
				col_q       <= '0;
				row_q       <= '0;
				rb_q        <= '0;
				cb_q        <= '0;
				drain_idx_q <= '0;
				pend_q      <= 1'b0;
			end else begin
				state_q <= state_d;
				if (accept) begin
					if (!col_end) begin
						col_q <= col_q + POS_W'(1);
					end else begin
						col_q <= '0;
						row_q <= row_end ? '0 : row_q + POS_W'(1);
					end
				end
				if (drain_rd) begin
					drain_idx_q <= drain_idx_q + CNT_W'(1);
					pend_q      <= 1'b1;
				end else if (out_load) begin
					pend_q <= 1'b0;
				end
				if (drain_done) begin
					drain_idx_q <= '0;
					if (rb_wrap) begin
						rb_q <= '0;
						cb_q <= cb_wrap ? '0 : cb_inc[BLK_W-1:0];
					end else begin
						rb_q <= rb_inc[BLK_W-1:0];
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/sign_pack_tile_transpose.sv
// Top level: sign binarize, bit pack and transpose of a matrix in square tiles.
//
//   channel   direction  handshake               words
//   sample    in         in_valid / in_stall     sample_value
//   result    out        out_valid / out_stall   packed_word, out_row, out_col, tile_last
//   config    in/out     APB (psel, penable)     num_rows @0x0, num_cols @0x4
//
// Cycles: one sample word a cycle inside a tile (read-modify-write of the column
// entry, forwarded when the same entry is hit on consecutive cycles). After the
// tile's last sample the input stalls through the flush and drain states while the store is
// drained one column word a cycle, longer if out_stall holds the output register.
// Reset: the valid bits of the store clear at once, no clearing pass is needed.
// A config write restarts the matrix at tile (0,0) with an empty store.
`default_nettype none
`include "sign_pack_tile_transpose_macros.svh"
module sign_pack_tile_transpose import spt_pkg::*; #(
	parameter int TILE_SIZE   = TILE_SIZE_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// sample channel
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [SAMPLE_BITS-1:0] sample_value,
	// result channel
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic      [TILE_SIZE-1:0]   packed_word,
	output logic      [DIM_W-1:0]       out_row,
	output logic      [OUT_COL_W-1:0]   out_col,
	output logic                        tile_last,
	// config port
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [2:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic      [31:0]            prdata,
	output logic                        pready
);

	localparam int POS_W = $clog2(TILE_SIZE);

	// config registers
	logic [DIM_W-1:0] num_rows_q, num_cols_q;
	logic [DIM_W-1:0] nr_eff, nc_eff;
	logic             cfg_wr;

	// store interface
	store_ctl_t           st_ctl;
	logic [POS_W-1:0]     rd_addr, wr_addr;
	logic [TILE_SIZE-1:0] wr_data, rd_word;

	// output register
	logic                 out_free, out_load;
	logic [TILE_SIZE-1:0] out_word_d;
	logic [DIM_W-1:0]     out_row_d;
	logic [OUT_COL_W-1:0] out_col_d;
	logic                 out_last_d;
	logic                 out_valid_q;
	logic [TILE_SIZE-1:0] packed_word_q;
	logic [DIM_W-1:0]     out_row_q;
	logic [OUT_COL_W-1:0] out_col_q;
	logic                 tile_last_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = 32'((paddr[2] == REG_NUM_COLS) ? num_cols_q : num_rows_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= DIM_RESET;
			num_cols_q <= DIM_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_NUM_ROWS) begin
				num_rows_q <= pwdata[DIM_W-1:0];
			end else begin
				num_cols_q <= pwdata[DIM_W-1:0];
			end
		end
	end

	// zero means one
	assign nr_eff = (num_rows_q == '0) ? DIM_W'(1) : num_rows_q;
	assign nc_eff = (num_cols_q == '0) ? DIM_W'(1) : num_cols_q;

	spt_ctrl #(
		.TILE_SIZE (TILE_SIZE)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_wr),
		.nr_eff     (nr_eff),
		.nc_eff     (nc_eff),
		.item_valid (in_valid),
		.item_stall (in_stall),
		.item_neg   (sample_value[SAMPLE_BITS-1]),
		.out_free   (out_free),
		.rd_word    (rd_word),
		.st_ctl     (st_ctl),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.out_load   (out_load),
		.out_word_d (out_word_d),
		.out_row_d  (out_row_d),
		.out_col_d  (out_col_d),
		.out_last_d (out_last_d)
	);

	spt_store #(
		.TILE_SIZE (TILE_SIZE)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (st_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_word (rd_word)
	);

	// output register; refilled in the cycle the consumer takes the old word
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			packed_word_q <= out_word_d;
			out_row_q     <= out_row_d;
			out_col_q     <= out_col_d;
			tile_last_q   <= out_last_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign packed_word = packed_word_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign tile_last   = tile_last_q;

	// a held word is never overwritten
	`SPT_ASSERT_NOW(a_no_overwrite, out_load, !(out_valid && out_stall), "held word overwritten")
	// every accepted sample is written back the next cycle
	`SPT_ASSERT_NEXT(a_rmw_write, in_valid && !in_stall, st_ctl.wr_en, "sample write lost")
	// the input reopens after the tile's last word is loaded, once the drain ends and the state returns to run
	`SPT_ASSERT_LATER2(a_reopen, out_load && out_last_d, !in_stall, "input not reopened")

endmodule
`default_nettype wire
